// ----- rtl/fsk_pkg.sv -----
package fsk_pkg;

    typedef enum logic [1:0] {
        CMD_FWD     = 2'd0,
        CMD_INV     = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_REWIND  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [6:0]  schedule_steps;
        logic [6:0]  last_round;
        logic [6:0]  first_round;
        logic [63:0] tk3_hi;
        logic [63:0] tk3_lo;
        logic [63:0] tk2_hi;
        logic [63:0] tk2_lo;
        logic [63:0] tk1_hi;
        logic [63:0] tk1_lo;
        logic [63:0] state_hi;
        logic [63:0] state_lo;
        logic [1:0]  cmd;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_tk3_hi;
        logic [63:0] out_tk3_lo;
        logic [63:0] out_tk2_hi;
        logic [63:0] out_tk2_lo;
        logic [63:0] out_tk1_hi;
        logic [63:0] out_tk1_lo;
        logic [63:0] out_state_hi;
        logic [63:0] out_state_lo;
    } out_item_t;

    typedef struct packed {
        logic [127:0] st;
        logic [127:0] tk1;
        logic [127:0] tk2;
        logic [127:0] tk3;
    } work_t;

    typedef struct packed {
        logic       fwd_round;
        logic       inv_round;
        logic       sched_fwd;
        logic       sched_bwd;
        logic [6:0] rc_idx;
    } op_t;

    localparam int RC_MAX = 87;

    function automatic logic [6:0] rcon(input logic [6:0] i);
        logic [6:0] r;
        r = 7'h01;
        case (i)
            7'd0: r = 7'h01;  7'd1: r = 7'h03;  7'd2: r = 7'h07;  7'd3: r = 7'h0f;
            7'd4: r = 7'h1f;  7'd5: r = 7'h3f;  7'd6: r = 7'h7e;  7'd7: r = 7'h7d;
            7'd8: r = 7'h7b;  7'd9: r = 7'h77;  7'd10: r = 7'h6f; 7'd11: r = 7'h5f;
            7'd12: r = 7'h3e; 7'd13: r = 7'h7c; 7'd14: r = 7'h79; 7'd15: r = 7'h73;
            7'd16: r = 7'h67; 7'd17: r = 7'h4f; 7'd18: r = 7'h1e; 7'd19: r = 7'h3d;
            7'd20: r = 7'h7a; 7'd21: r = 7'h75; 7'd22: r = 7'h6b; 7'd23: r = 7'h57;
            7'd24: r = 7'h2e; 7'd25: r = 7'h5c; 7'd26: r = 7'h38; 7'd27: r = 7'h70;
            7'd28: r = 7'h61; 7'd29: r = 7'h43; 7'd30: r = 7'h06; 7'd31: r = 7'h0d;
            7'd32: r = 7'h1b; 7'd33: r = 7'h37; 7'd34: r = 7'h6e; 7'd35: r = 7'h5d;
            7'd36: r = 7'h3a; 7'd37: r = 7'h74; 7'd38: r = 7'h69; 7'd39: r = 7'h53;
            7'd40: r = 7'h26; 7'd41: r = 7'h4c; 7'd42: r = 7'h18; 7'd43: r = 7'h31;
            7'd44: r = 7'h62; 7'd45: r = 7'h45; 7'd46: r = 7'h0a; 7'd47: r = 7'h15;
            7'd48: r = 7'h2b; 7'd49: r = 7'h56; 7'd50: r = 7'h2c; 7'd51: r = 7'h58;
            7'd52: r = 7'h30; 7'd53: r = 7'h60; 7'd54: r = 7'h41; 7'd55: r = 7'h02;
            7'd56: r = 7'h05; 7'd57: r = 7'h0b; 7'd58: r = 7'h17; 7'd59: r = 7'h2f;
            7'd60: r = 7'h5e; 7'd61: r = 7'h3c; 7'd62: r = 7'h78; 7'd63: r = 7'h71;
            7'd64: r = 7'h63; 7'd65: r = 7'h47; 7'd66: r = 7'h0e; 7'd67: r = 7'h1d;
            7'd68: r = 7'h3b; 7'd69: r = 7'h76; 7'd70: r = 7'h6d; 7'd71: r = 7'h5b;
            7'd72: r = 7'h36; 7'd73: r = 7'h6c; 7'd74: r = 7'h59; 7'd75: r = 7'h32;
            7'd76: r = 7'h64; 7'd77: r = 7'h49; 7'd78: r = 7'h12; 7'd79: r = 7'h25;
            7'd80: r = 7'h4a; 7'd81: r = 7'h14; 7'd82: r = 7'h29; 7'd83: r = 7'h52;
            7'd84: r = 7'h24; 7'd85: r = 7'h48; 7'd86: r = 7'h10;
            default: r = 7'h01;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/fsk_round.sv -----
module fsk_round (
    input  fsk_pkg::work_t w,
    input  fsk_pkg::op_t   op,
    output fsk_pkg::work_t y
);

    localparam logic [3:0] PERM [16] = '{4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12,
        4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};

    function automatic logic [31:0] nor_mix(input logic [31:0] x);
        return ((~(((x >> 1) | x) >> 2)) & 32'h11111111) ^ x;
    endfunction

    function automatic logic [31:0] bperm(input logic [31:0] x);
        return ((x & 32'h01010101) << 2) | ((x & 32'h06060606) << 5) |
               ((x & 32'h20202020) >> 5) | ((x & 32'hC8C8C8C8) >> 2) |
               ((x & 32'h10101010) >> 1);
    endfunction

    function automatic logic [31:0] bperm_inv(input logic [31:0] x);
        return ((x & 32'h04040404) >> 2) | ((x & 32'hC0C0C0C0) >> 5) |
               ((x & 32'h01010101) << 5) | ((x & 32'h32323232) << 2) |
               ((x & 32'h08080808) << 1);
    endfunction

    function automatic logic [31:0] swap12(input logic [31:0] x);
        return (x & 32'hF9F9F9F9) | ((x >> 1) & 32'h02020202) | ((x << 1) & 32'h04040404);
    endfunction

    function automatic logic [31:0] sbox(input logic [31:0] x);
        return swap12(nor_mix(bperm(nor_mix(bperm(nor_mix(bperm(nor_mix(x))))))));
    endfunction

    function automatic logic [31:0] sbox_inv(input logic [31:0] x);
        return nor_mix(bperm_inv(nor_mix(bperm_inv(nor_mix(bperm_inv(nor_mix(swap12(x))))))));
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] cperm(input logic [127:0] c);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
        begin
            t[8*i +: 8] = c[8*PERM[i] +: 8];
        end
        return t;
    endfunction

    function automatic logic [127:0] cperm_inv(input logic [127:0] c);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
        begin
            t[8*PERM[i] +: 8] = c[8*i +: 8];
        end
        return t;
    endfunction

    function automatic logic [7:0] lfsr2(input logic [7:0] x);
        return {x[6:0], x[7] ^ x[5]};
    endfunction

    function automatic logic [7:0] lfsr3(input logic [7:0] x);
        return {x[0] ^ x[6], x[7:1]};
    endfunction

    logic [127:0] tf1, tf2, tf3, tb1, tb2, tb3, k1, k2, k3;
    logic [31:0]  r0, r1, r2, r3, t, key0, key1;
    logic [6:0]   c;

    always_comb
    begin
        tf1 = cperm(w.tk1);
        tf2 = cperm(w.tk2);
        tf3 = cperm(w.tk3);
        for (int i = 0; i < 8; i++)
        begin
            tf2[8*i +: 8] = lfsr2(tf2[8*i +: 8]);
            tf3[8*i +: 8] = lfsr3(tf3[8*i +: 8]);
        end
        tb2 = w.tk2;
        tb3 = w.tk3;
        for (int i = 0; i < 8; i++)
        begin
            tb2[8*i +: 8] = lfsr3(w.tk2[8*i +: 8]);
            tb3[8*i +: 8] = lfsr2(w.tk3[8*i +: 8]);
        end
        tb1 = cperm_inv(w.tk1);
        tb2 = cperm_inv(tb2);
        tb3 = cperm_inv(tb3);

        k1 = op.inv_round ? tb1 : w.tk1;
        k2 = op.inv_round ? tb2 : w.tk2;
        k3 = op.inv_round ? tb3 : w.tk3;
        c = fsk_pkg::rcon(op.rc_idx);
        key0 = k1[31:0] ^ k2[31:0] ^ k3[31:0] ^ {28'd0, c[3:0]} ^ 32'h00020000;
        key1 = k1[63:32] ^ k2[63:32] ^ k3[63:32] ^ {29'd0, c[6:4]};

        r0 = '0; r1 = '0; r2 = '0; r3 = '0; t = '0;
        y = w;
        if (op.fwd_round)
        begin
            r0 = sbox(w.st[31:0]) ^ key0;
            r1 = rotl(sbox(w.st[63:32]) ^ key1, 8);
            r2 = rotl(sbox(w.st[95:64]) ^ 32'h2, 16);
            r3 = rotl(sbox(w.st[127:96]), 24);
            r1 = r1 ^ r2;
            r2 = r2 ^ r0;
            t = r3 ^ r2;
            y.st = {r2, r1, r0, t};
        end
        else if (op.inv_round)
        begin
            r0 = w.st[63:32];
            r1 = w.st[95:64];
            r2 = w.st[127:96];
            r3 = w.st[31:0] ^ r2;
            r2 = r2 ^ r0;
            r1 = r1 ^ r2;
            r1 = rotl(r1, 24);
            r2 = rotl(r2, 16);
            r3 = rotl(r3, 8);
            y.st = {sbox_inv(r3), sbox_inv(r2 ^ 32'h2), sbox_inv(r1 ^ key1), sbox_inv(r0 ^ key0)};
        end
        if (op.fwd_round || op.sched_fwd)
        begin
            y.tk1 = tf1; y.tk2 = tf2; y.tk3 = tf3;
        end
        else if (op.inv_round || op.sched_bwd)
        begin
            y.tk1 = tb1; y.tk2 = tb2; y.tk3 = tb3;
        end
    end

endmodule

// ----- rtl/forkskinny_128_384_round_engine_top.sv -----
// the number of rounds or schedule steps per item is 0 to 87
// one round or schedule step per cycle through a single shared round unit
// no new item is taken while one is in flight
// reset: rst_n asynchronous active low, returns the sequencer to idle, no pending output
module forkskinny_128_384_round_engine_top #(
    parameter int ROUND_CONSTANT_COUNT = 87
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fsk_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fsk_pkg::out_item_t out_data
);

    localparam logic [6:0] RMAX = 7'(ROUND_CONSTANT_COUNT);

    fsk_pkg::state_t state_reg, state_next;
    fsk_pkg::work_t  work_reg, work_next, rnd_out;
    fsk_pkg::cmd_t   cmd_reg, cmd_next;
    logic [6:0]      a_reg, a_next, b_reg, b_next;
    fsk_pkg::op_t    op;
    logic [6:0]      fa, fb, fn;
    logic            busy;

    fsk_round u_round (.w(work_reg), .op(op), .y(rnd_out));

    assign fa = (in_data.first_round > RMAX) ? RMAX : in_data.first_round;
    assign fb = (in_data.last_round > RMAX) ? RMAX : in_data.last_round;
    assign fn = (in_data.schedule_steps > RMAX) ? RMAX : in_data.schedule_steps;

    always_comb
    begin
        busy = 1'b0;
        unique case (cmd_reg) inside
            fsk_pkg::CMD_FWD:     busy = a_reg < b_reg;
            fsk_pkg::CMD_INV:     busy = a_reg > b_reg;
            fsk_pkg::CMD_ADVANCE,
            fsk_pkg::CMD_REWIND:  busy = a_reg != 7'd0;
            default:              busy = 1'b0;
        endcase
        op.fwd_round = (state_reg == fsk_pkg::ST_RUN) && busy && cmd_reg == fsk_pkg::CMD_FWD;
        op.inv_round = (state_reg == fsk_pkg::ST_RUN) && busy && cmd_reg == fsk_pkg::CMD_INV;
        op.sched_fwd = (state_reg == fsk_pkg::ST_RUN) && busy
            && cmd_reg == fsk_pkg::CMD_ADVANCE;
        op.sched_bwd = (state_reg == fsk_pkg::ST_RUN) && busy
            && cmd_reg == fsk_pkg::CMD_REWIND;
        op.rc_idx = (cmd_reg == fsk_pkg::CMD_INV) ? a_reg - 7'd1 : a_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        cmd_next   = cmd_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            fsk_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = fsk_pkg::ST_RUN;
                    cmd_next   = fsk_pkg::cmd_t'(in_data.cmd);
                    work_next  = {in_data.state_hi, in_data.state_lo, in_data.tk1_hi,
                        in_data.tk1_lo, in_data.tk2_hi, in_data.tk2_lo, in_data.tk3_hi,
                        in_data.tk3_lo};
                    a_next = (in_data.cmd[1]) ? fn : fa;
                    b_next = fb;
                end
            end
            fsk_pkg::ST_RUN:
            begin
                work_next = rnd_out;
                if (!busy)
                begin
                    state_next = fsk_pkg::ST_DONE;
                end
                else if (cmd_reg == fsk_pkg::CMD_FWD)
                begin
                    a_next = a_reg + 7'd1;
                end
                else
                begin
                    a_next = a_reg - 7'd1;
                end
            end
            fsk_pkg::ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = fsk_pkg::ST_IDLE;
                end
            end
            default: state_next = fsk_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        cmd_reg  <= cmd_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

    assign out_valid = state_reg == fsk_pkg::ST_DONE;
    assign out_data  = {work_reg.tk3[127:64], work_reg.tk3[63:0], work_reg.tk2[127:64],
        work_reg.tk2[63:0], work_reg.tk1[127:64], work_reg.tk1[63:0],
        work_reg.st[127:64], work_reg.st[63:0]};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != fsk_pkg::ST_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_run_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == fsk_pkg::ST_RUN)
        else $error("transfer did not start work");
    a_rounds_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fsk_pkg::ST_RUN |-> a_reg <= RMAX)
        else $error("round index out of range");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int ROUND_LIMIT = 87;
    localparam int TAIL_CYCLES = 120;

    class skinny_scoreboard;
        fsk_pkg::out_item_t pending[$];
        int errors;

        static function bit [7:0] sbox(bit [7:0] x);
            bit [7:0] y;
            y = x;
            for (int i = 0; i < 3; i++)
            begin
                y = {y[7:5], y[4] ^ ~(y[7] | y[6]), y[3:1], y[0] ^ ~(y[3] | y[2])};
                y = {y[2], y[1], y[7], y[6], y[4], y[0], y[3], y[5]};
            end
            y = {y[7:5], y[4] ^ ~(y[7] | y[6]), y[3:1], y[0] ^ ~(y[3] | y[2])};
            return {y[7:3], y[1], y[2], y[0]};
        endfunction

        static function bit [7:0] sbox_inv(bit [7:0] x);
            for (int v = 0; v < 256; v++)
                if (sbox(v[7:0]) == x)
                    return v[7:0];
            return 8'h00;
        endfunction

        static function bit [31:0] sub_row(bit [31:0] r, bit inv);
            bit [31:0] o;
            for (int j = 0; j < 4; j++)
                o[8*j +: 8] = inv ? sbox_inv(r[8*j +: 8]) : sbox(r[8*j +: 8]);
            return o;
        endfunction

        static function bit [31:0] rotl(bit [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        static function bit [6:0] round_const(int i);
            bit [6:0] r;
            r = 7'h01;
            for (int k = 0; k < i; k++)
                r = {r[5:0], r[6] ^ r[5] ^ 1'b1};
            return r;
        endfunction

        static function bit [127:0] tk_permute(bit [127:0] t, bit inv);
            int p[16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};
            bit [127:0] o;
            for (int i = 0; i < 16; i++)
                if (inv)
                    o[8*p[i] +: 8] = t[8*i +: 8];
                else
                    o[8*i +: 8] = t[8*p[i] +: 8];
            return o;
        endfunction

        static function void tweakey_step(ref bit [127:0] tk[3], input bit back);
            bit [7:0] b;
            if (!back)
                for (int k = 0; k < 3; k++)
                    tk[k] = tk_permute(tk[k], 1'b0);
            for (int i = 0; i < 8; i++)
            begin
                b = tk[1][8*i +: 8];
                tk[1][8*i +: 8] = back ? {b[0] ^ b[6], b[7:1]} : {b[6:0], b[7] ^ b[5]};
                b = tk[2][8*i +: 8];
                tk[2][8*i +: 8] = back ? {b[6:0], b[7] ^ b[5]} : {b[0] ^ b[6], b[7:1]};
            end
            if (back)
                for (int k = 0; k < 3; k++)
                    tk[k] = tk_permute(tk[k], 1'b1);
        endfunction

        static function fsk_pkg::out_item_t run_command(fsk_pkg::in_item_t it);
            bit [31:0] row[4];
            bit [31:0] t;
            bit [127:0] tk[3];
            bit [127:0] x;
            bit [6:0] c;
            int a, b, n;
            fsk_pkg::out_item_t o;
            a = it.first_round > ROUND_LIMIT ? ROUND_LIMIT : it.first_round;
            b = it.last_round > ROUND_LIMIT ? ROUND_LIMIT : it.last_round;
            n = it.schedule_steps > ROUND_LIMIT ? ROUND_LIMIT : it.schedule_steps;
            row[0] = it.state_lo[31:0];
            row[1] = it.state_lo[63:32];
            row[2] = it.state_hi[31:0];
            row[3] = it.state_hi[63:32];
            tk[0] = {it.tk1_hi, it.tk1_lo};
            tk[1] = {it.tk2_hi, it.tk2_lo};
            tk[2] = {it.tk3_hi, it.tk3_lo};
            case (fsk_pkg::cmd_t'(it.cmd))
                fsk_pkg::CMD_FWD:
                    for (; a < b; a++)
                    begin
                        for (int k = 0; k < 4; k++)
                            row[k] = sub_row(row[k], 1'b0);
                        c = round_const(a);
                        x = tk[0] ^ tk[1] ^ tk[2];
                        row[0] ^= x[31:0] ^ {28'h0, c[3:0]} ^ 32'h00020000;
                        row[1] ^= x[63:32] ^ {29'h0, c[6:4]};
                        row[2] ^= 32'h02;
                        row[1] = rotl(row[1], 8);
                        row[2] = rotl(row[2], 16);
                        row[3] = rotl(row[3], 24);
                        row[1] ^= row[2];
                        row[2] ^= row[0];
                        t = row[3] ^ row[2];
                        row[3] = row[2];
                        row[2] = row[1];
                        row[1] = row[0];
                        row[0] = t;
                        tweakey_step(tk, 1'b0);
                    end
                fsk_pkg::CMD_INV:
                    while (a > b)
                    begin
                        tweakey_step(tk, 1'b1);
                        t = row[0];
                        row[0] = row[1];
                        row[1] = row[2];
                        row[2] = row[3];
                        row[3] = t ^ row[2];
                        row[2] ^= row[0];
                        row[1] ^= row[2];
                        row[1] = rotl(row[1], 24);
                        row[2] = rotl(row[2], 16);
                        row[3] = rotl(row[3], 8);
                        a--;
                        c = round_const(a);
                        x = tk[0] ^ tk[1] ^ tk[2];
                        row[0] ^= x[31:0] ^ {28'h0, c[3:0]} ^ 32'h00020000;
                        row[1] ^= x[63:32] ^ {29'h0, c[6:4]};
                        row[2] ^= 32'h02;
                        for (int k = 0; k < 4; k++)
                            row[k] = sub_row(row[k], 1'b1);
                    end
                fsk_pkg::CMD_ADVANCE:
                    for (; n > 0; n--)
                        tweakey_step(tk, 1'b0);
                default:
                    for (; n > 0; n--)
                        tweakey_step(tk, 1'b1);
            endcase
            o.out_state_lo = {row[1], row[0]};
            o.out_state_hi = {row[3], row[2]};
            {o.out_tk1_hi, o.out_tk1_lo} = tk[0];
            {o.out_tk2_hi, o.out_tk2_lo} = tk[1];
            {o.out_tk3_hi, o.out_tk3_lo} = tk[2];
            return o;
        endfunction

        function void note_command(fsk_pkg::in_item_t it);
            pending.push_back(run_command(it));
        endfunction

        function void check_result(fsk_pkg::out_item_t got);
            fsk_pkg::out_item_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            for (int f = 0; f < 8; f++)
                if (exp[64*f +: 64] !== got[64*f +: 64])
                begin
                    $display("%0t: field %0d expected %h actual %h", $time, f,
                             exp[64*f +: 64], got[64*f +: 64]);
                    errors++;
                end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    fsk_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    fsk_pkg::out_item_t out_data;
    bit quiet;

    skinny_scoreboard sb = new();

    forkskinny_128_384_round_engine_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("forkskinny_128_384_round_engine_top test failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [6:0] rand_round();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 7'($urandom_range(88, 127));
        if (r < 7)
            return 7'($urandom_range(0, 12));
        return 7'($urandom_range(0, 87));
    endfunction

    function automatic fsk_pkg::in_item_t rand_item();
        fsk_pkg::in_item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        it.state_lo = rand64();
        it.state_hi = rand64();
        it.tk1_lo = rand64();
        it.tk1_hi = rand64();
        it.tk2_lo = rand64();
        it.tk2_hi = rand64();
        it.tk3_lo = $urandom_range(0, 3) == 0 ? 64'h0 : rand64();
        it.tk3_hi = it.tk3_lo == 64'h0 ? 64'h0 : rand64();
        it.first_round = rand_round();
        it.last_round = rand_round();
        it.schedule_steps = rand_round();
        return it;
    endfunction

    task automatic send_command(fsk_pkg::in_item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_command(it);
        in_valid <= 1'b0;
        // the block stays busy after a transfer, through its run and done states
        @(posedge clk);
    endtask

    task automatic directed_part();
        fsk_pkg::in_item_t it;
        for (int i = 0; i < 24; i++)
        begin
            it = rand_item();
            it.cmd = 2'(i % 4);
            case (i / 4)
                0: begin it.first_round = 7'd0; it.last_round = 7'd87; it.schedule_steps = 7'd87; end
                1: begin it.first_round = 7'd87; it.last_round = 7'd0; it.schedule_steps = 7'd0; end
                2: begin it.first_round = 7'd127; it.last_round = 7'd127; it.schedule_steps = 7'd127; end
                3: begin it.first_round = 7'd5; it.last_round = 7'd5; it.schedule_steps = 7'd1; end
                4: begin it.first_round = 7'd0; it.last_round = 7'd127; it.schedule_steps = 7'd100; end
                default: begin it.first_round = 7'd127; it.last_round = 7'd0; end
            endcase
            if (i == 20)
                it = '0;
            if (i == 21)
            begin
                it = '1;
                it.cmd = fsk_pkg::CMD_INV;
            end
            send_command(it);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        quiet = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        for (int i = 0; i < 750; i++)
        begin
            if (i == 300)
                while (sb.pending.size() != 0)
                    @(posedge clk);
            if (i == 650)
                quiet = 1'b1;
            send_command(rand_item());
        end
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("forkskinny_128_384_round_engine_top test passed");
        else
            $display("forkskinny_128_384_round_engine_top test failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/fsk_pkg.sv
rtl/fsk_round.sv
rtl/forkskinny_128_384_round_engine_top.sv
verif/testbench.sv
